// ===== rtl/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsp_pkg: shared types and helpers for the speed-profile interpolator
// Item layouts, status codes, controller/datapath interface and rounding.
// ----------------------------------------------------------------------------
`default_nettype none

package lsp_pkg;

  localparam int MAX_POINTS = 8;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int ACC_W      = 32 + $clog2(MAX_POINTS) + 1;
  localparam int PC_W       = 4;
  localparam logic [PC_W-1:0] PC_RESET = 4'd4;

  localparam logic       CMD_LOAD = 1'b0;
  localparam logic       CMD_EVAL = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EQUAL = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [2:0]        point_index;
    logic signed [31:0] node_time;
    logic signed [31:0] node_turn_rate;
    logic signed [31:0] node_speed;
    logic signed [31:0] eval_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] lin_speed;
    logic signed [31:0] turn_rate;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_LOAD_XI,
    OP_BASIS_INIT,
    OP_DIV_START,
    OP_MUL_F,
    OP_RND_B,
    OP_MUL_W,
    OP_RND_W,
    OP_MUL_V,
    OP_RND_V,
    OP_PUSH,
    OP_PUSH_ERR
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
  } dp_cmd_t;

  typedef struct packed {
    logic eq;
    logic div_done;
    logic out_free;
  } dp_stat_t;

  // p / 2^16, rounded half away from zero, saturated; returns {sat, value}
  function automatic logic [32:0] qround(input logic signed [63:0] p);
    logic [63:0] m;
    logic [47:0] r;
    logic [32:0] res;
    m = p[63] ? (64'd0 - 64'(p)) : 64'(p);
    r = 48'((m + 64'h8000) >> 16);
    if (p[63]) begin
      if (r > 48'h8000_0000) res = {1'b1, 32'h8000_0000};
      else                    res = {1'b0, 32'(48'd0 - r)};
    end else begin
      if (r > 48'h7FFF_FFFF) res = {1'b1, 32'h7FFF_FFFF};
      else                    res = {1'b0, r[31:0]};
    end
    return res;
  endfunction

  function automatic logic [32:0] sat_acc(input logic signed [ACC_W-1:0] a);
    logic [32:0] res;
    if (a > ACC_W'(signed'(33'sh0_7FFF_FFFF)))       res = {1'b1, 32'h7FFF_FFFF};
    else if (a < ACC_W'(signed'(33'sh1_8000_0000)))  res = {1'b1, 32'h8000_0000};
    else                                             res = {1'b0, a[31:0]};
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lagrange_speed_profile.sv =====
// ----------------------------------------------------------------------------
// lagrange_speed_profile: Lagrange interpolation of a waypoint speed profile
// Loads waypoints and evaluates linear speed and turn rate at a given time.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_ready_o  in_item_i (lsp_pkg::in_item_t)
//   out      source     out_valid_o/out_ready_i out_item_o (lsp_pkg::out_item_t)
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_data_i (point_count)
//
// Load items are taken back to back while idle. An evaluate item with k points
// runs one division per basis factor on the shared 50-step radix-2 divider,
// and intake stays closed until its result is pushed. Equal node times
// finish after the check.
// Reset clears control only; stores hold nothing until loaded.
// A result waiting on out_ready_i stalls the next evaluate at its final step.
`default_nettype none

module lagrange_speed_profile (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire lsp_pkg::in_item_t         in_item_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output lsp_pkg::out_item_t             out_item_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [lsp_pkg::PC_W-1:0] cfg_data_i
);
  import lsp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     ld_en;

  assign cfg_ready_o = 1'b1;

  lsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_cmd_i    (in_item_i.cmd),
    .ld_en_o     (ld_en),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  lsp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_en_i     (ld_en),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== rtl/lsp_div.sv =====
// ----------------------------------------------------------------------------
// lsp_div: basis-factor divider
// Restoring radix-2 divider for n * 2^16 / d, rounded, saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [32:0] n_i,
  input  wire logic signed [32:0] d_i,
  output logic                    done_o,
  output logic signed [31:0]      q_o,
  output logic                    ovf_o
);
  localparam int NUM_W = 50;
  localparam int DEN_W = 34;

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             neg_q, neg_d;
  logic             done_q, done_d;
  logic signed [31:0] res_q, res_d;
  logic             ovf_q, ovf_d;

  logic [32:0]    nm, dm;
  logic [DEN_W:0] rem_sh;
  logic           fits;

  always_comb begin
    nm     = n_i[32] ? (33'd0 - 33'(n_i)) : 33'(n_i);
    dm     = d_i[32] ? (33'd0 - 33'(d_i)) : 33'(d_i);
    rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
    fits   = rem_sh >= {1'b0, den_q};

    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    res_d  = res_q;
    ovf_d  = ovf_q;

    if (start_i) begin
      num_d  = {nm, 17'd0} + NUM_W'(dm);
      den_d  = {dm, 1'b0};
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 6'(NUM_W);
      busy_d = 1'b1;
      neg_d  = n_i[32] ^ d_i[32];
    end else if (busy_q) begin
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (neg_q) begin
          ovf_d = quo_q > NUM_W'(64'h8000_0000);
          res_d = ovf_d ? 32'sh8000_0000 : 32'(NUM_W'(0) - quo_q);
        end else begin
          ovf_d = quo_q > NUM_W'(64'h7FFF_FFFF);
          res_d = ovf_d ? 32'sh7FFF_FFFF : 32'(quo_q);
        end
      end else begin
        rem_d = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
        quo_d = {quo_q[NUM_W-2:0], fits};
        num_d = {num_q[NUM_W-2:0], 1'b0};
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    res_q <= res_d;
    ovf_q <= ovf_d;
  end

  assign done_o = done_q;
  assign q_o    = res_q;
  assign ovf_o  = ovf_q;

endmodule

`default_nettype wire

// ===== rtl/lsp_datapath.sv =====
// ----------------------------------------------------------------------------
// lsp_datapath: waypoint stores, divider, multiplier, accumulators and output register
// Executes one controller command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             ld_en_i,
  input  wire lsp_pkg::in_item_t in_item_i,
  input  wire lsp_pkg::dp_cmd_t  cmd_i,
  output lsp_pkg::dp_stat_t      stat_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output lsp_pkg::out_item_t     out_item_o
);
  import lsp_pkg::*;

  logic signed [31:0] time_mem  [MAX_POINTS];
  logic signed [31:0] turn_mem  [MAX_POINTS];
  logic signed [31:0] speed_mem [MAX_POINTS];

  logic signed [31:0] t_q, xi_q, basis_q;
  logic signed [63:0] prod_q;
  logic signed [ACC_W-1:0] acc_w_q, acc_v_q;
  logic               flag_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic [IDX_W-1:0]   taddr;
  logic signed [31:0] trd;
  logic signed [31:0] mul_b;
  logic [32:0]        rnd, sat_w, sat_v;
  logic               div_done, div_ovf;
  logic signed [31:0] div_q;
  logic               div_start;
  logic signed [32:0] div_n, div_d;

  assign taddr = (cmd_i.op == OP_LOAD_XI || cmd_i.op == OP_BASIS_INIT) ? cmd_i.i : cmd_i.j;
  assign trd   = time_mem[taddr];

  assign div_start = cmd_i.op == OP_DIV_START;
  assign div_n     = 33'(t_q) - 33'(trd);
  assign div_d     = 33'(xi_q) - 33'(trd);

  lsp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (div_n),
    .d_i     (div_d),
    .done_o  (div_done),
    .q_o     (div_q),
    .ovf_o   (div_ovf)
  );

  always_comb begin
    unique case (cmd_i.op)
      OP_MUL_W: mul_b = turn_mem[cmd_i.i];
      OP_MUL_V: mul_b = speed_mem[cmd_i.i];
      default:  mul_b = div_q;
    endcase
  end

  assign rnd   = qround(prod_q);
  assign sat_w = sat_acc(acc_w_q);
  assign sat_v = sat_acc(acc_v_q);

  assign stat_o.eq       = xi_q == trd;
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (ld_en_i && (32'(in_item_i.point_index) < MAX_POINTS)) begin
      time_mem[IDX_W'(in_item_i.point_index)]  <= in_item_i.node_time;
      turn_mem[IDX_W'(in_item_i.point_index)]  <= in_item_i.node_turn_rate;
      speed_mem[IDX_W'(in_item_i.point_index)] <= in_item_i.node_speed;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_START: begin
        t_q     <= in_item_i.eval_time;
        acc_w_q <= '0;
        acc_v_q <= '0;
        flag_q  <= 1'b0;
      end
      OP_LOAD_XI: xi_q <= trd;
      OP_BASIS_INIT: begin
        xi_q    <= trd;
        basis_q <= 32'sh0001_0000;
      end
      OP_MUL_F: begin
        prod_q <= basis_q * mul_b;
        flag_q <= flag_q | div_ovf;
      end
      OP_MUL_W, OP_MUL_V: prod_q <= basis_q * mul_b;
      OP_RND_B: begin
        basis_q <= rnd[31:0];
        flag_q  <= flag_q | rnd[32];
      end
      OP_RND_W: begin
        acc_w_q <= acc_w_q + ACC_W'(signed'(rnd[31:0]));
        flag_q  <= flag_q | rnd[32];
      end
      OP_RND_V: begin
        acc_v_q <= acc_v_q + ACC_W'(signed'(rnd[31:0]));
        flag_q  <= flag_q | rnd[32];
      end
      OP_PUSH: begin
        out_q.lin_speed <= sat_v[31:0];
        out_q.turn_rate <= sat_w[31:0];
        out_q.status    <= (flag_q || sat_v[32] || sat_w[32]) ? ST_SAT : ST_OK;
      end
      OP_PUSH_ERR: begin
        out_q.lin_speed <= '0;
        out_q.turn_rate <= '0;
        out_q.status    <= ST_EQUAL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_PUSH || cmd_i.op == OP_PUSH_ERR) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/lsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsp_ctrl: sequencer for waypoint checks, basis products and sums
// Holds point_count and walks the (i, j) loops, issuing datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       in_cmd_i,
  output logic                            ld_en_o,
  input  wire logic                       cfg_valid_i,
  input  wire logic [lsp_pkg::PC_W-1:0]   cfg_data_i,
  output lsp_pkg::dp_cmd_t                 cmd_o,
  input  wire lsp_pkg::dp_stat_t           stat_i
);
  import lsp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK_I, S_CHK_J, S_BAS_INIT, S_FAC, S_DIV, S_RND_F,
    S_MUL_W, S_RND_W, S_MUL_V, S_RND_V, S_PUSH, S_ERR
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] k_q, k_d, i_q, i_d, j_q, j_d;
  logic [PC_W-1:0]  pc_q;
  logic [CNT_W-1:0] k_clamp;
  logic             acc;

  assign in_ready_o = state_q == S_IDLE;
  assign acc        = in_valid_i && in_ready_o;
  assign ld_en_o    = acc && (in_cmd_i == CMD_LOAD);

  always_comb begin
    if (pc_q == '0)                       k_clamp = CNT_W'(1);
    else if (32'(pc_q) > MAX_POINTS)      k_clamp = CNT_W'(MAX_POINTS);
    else                                  k_clamp = CNT_W'(pc_q);
  end

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    i_d      = i_q;
    j_d      = j_q;
    cmd_o.op = OP_NONE;
    cmd_o.i  = i_q[IDX_W-1:0];
    cmd_o.j  = j_q[IDX_W-1:0];
    unique case (state_q)
      S_IDLE: if (acc && in_cmd_i == CMD_EVAL) begin
        cmd_o.op = OP_START;
        k_d      = k_clamp;
        i_d      = '0;
        state_d  = S_CHK_I;
      end
      S_CHK_I: begin
        if (i_q == k_q - CNT_W'(1)) begin
          i_d     = '0;
          state_d = S_BAS_INIT;
        end else begin
          cmd_o.op = OP_LOAD_XI;
          j_d      = i_q + CNT_W'(1);
          state_d  = S_CHK_J;
        end
      end
      S_CHK_J: begin
        if (stat_i.eq) begin
          state_d = S_ERR;
        end else if (j_q == k_q - CNT_W'(1)) begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_CHK_I;
        end else begin
          j_d = j_q + CNT_W'(1);
        end
      end
      S_BAS_INIT: begin
        cmd_o.op = OP_BASIS_INIT;
        j_d      = '0;
        state_d  = S_FAC;
      end
      S_FAC: begin
        if (j_q == k_q) begin
          state_d = S_MUL_W;
        end else if (j_q == i_q) begin
          j_d = j_q + CNT_W'(1);
        end else begin
          cmd_o.op = OP_DIV_START;
          state_d  = S_DIV;
        end
      end
      S_DIV: if (stat_i.div_done) begin
        cmd_o.op = OP_MUL_F;
        state_d  = S_RND_F;
      end
      S_RND_F: begin
        cmd_o.op = OP_RND_B;
        j_d      = j_q + CNT_W'(1);
        state_d  = S_FAC;
      end
      S_MUL_W: begin
        cmd_o.op = OP_MUL_W;
        state_d  = S_RND_W;
      end
      S_RND_W: begin
        cmd_o.op = OP_RND_W;
        state_d  = S_MUL_V;
      end
      S_MUL_V: begin
        cmd_o.op = OP_MUL_V;
        state_d  = S_RND_V;
      end
      S_RND_V: begin
        cmd_o.op = OP_RND_V;
        i_d      = i_q + CNT_W'(1);
        state_d  = (i_q == k_q - CNT_W'(1)) ? S_PUSH : S_BAS_INIT;
      end
      S_PUSH: if (stat_i.out_free) begin
        cmd_o.op = OP_PUSH;
        state_d  = S_IDLE;
      end
      S_ERR: if (stat_i.out_free) begin
        cmd_o.op = OP_PUSH_ERR;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      pc_q    <= PC_RESET;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      i_q     <= i_d;
      j_q     <= j_d;
      if (cfg_valid_i) begin
        pc_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lsp_checker.sv =====
// ----------------------------------------------------------------------------
// lsp_checker: port-level checks for the speed-profile interpolator
// Observes the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire lsp_pkg::in_item_t   in_item_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire lsp_pkg::out_item_t  out_item_o
);
  import lsp_pkg::*;

  // an evaluate item blocks intake for at least the next cycle
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.cmd == CMD_EVAL |=> !in_ready_o)
    else $error("intake open right after evaluate");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result dropped or changed while stalled");

  a_equal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_EQUAL |->
      out_item_o.lin_speed == 32'sd0 && out_item_o.turn_rate == 32'sd0)
    else $error("equal-node result not zero");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.status == ST_OK || out_item_o.status == ST_EQUAL ||
      out_item_o.status == ST_SAT)
    else $error("bad status code");

endmodule

bind lagrange_speed_profile lsp_checker u_lsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

// ===== tb/lsp_checker.sv =====
// ----------------------------------------------------------------------------
// lsp_scoreboard: result predictor and scoreboard for lagrange_speed_profile
// Watches the in, out and cfg channels. It keeps its own waypoint table and
// point count, predicts each evaluate result in Q16.16 and compares every
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module lsp_scoreboard (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  lsp_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  lsp_pkg::out_item_t out_item_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [3:0]         cfg_data_i,
  output int                 errors_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lsp_pkg::*;

  longint             wp_time  [MAX_POINTS];
  longint             wp_turn  [MAX_POINTS];
  longint             wp_speed [MAX_POINTS];
  logic [3:0]         npoints;
  out_item_t          profile_q [$];
  int                 mismatches;

  function automatic longint clamp32(input longint v, inout bit sat);
    if (v > 64'sh7FFF_FFFF) begin
      sat = 1;
      return 64'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      sat = 1;
      return -64'sh8000_0000;
    end
    return v;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b, inout bit sat);
    longint p;
    longint m;
    p = a * b;
    m = ((p < 0 ? -p : p) + 64'sh8000) >>> 16;
    return clamp32(p < 0 ? -m : m, sat);
  endfunction

  function automatic longint fx_div(input longint n, input longint d, inout bit sat);
    longint nm;
    longint dm;
    longint q;
    nm = (n < 0 ? -n : n) <<< 16;
    dm = d < 0 ? -d : d;
    q  = (2 * nm + dm) / (2 * dm);
    return clamp32(((n < 0) != (d < 0)) ? -q : q, sat);
  endfunction

  function automatic out_item_t interpolate(input logic signed [31:0] t_in);
    out_item_t r;
    int        k;
    bit        sat;
    longint    t;
    longint    basis;
    longint    acc_v;
    longint    acc_w;
    k     = (npoints < 1) ? 1 : (npoints > MAX_POINTS) ? MAX_POINTS : int'(npoints);
    t     = longint'(t_in);
    sat   = 0;
    acc_v = 0;
    acc_w = 0;
    for (int i = 0; i < k; i++)
      for (int j = i + 1; j < k; j++)
        if (wp_time[i] == wp_time[j]) begin
          r.lin_speed = '0;
          r.turn_rate = '0;
          r.status    = ST_EQUAL;
          return r;
        end
    for (int i = 0; i < k; i++) begin
      basis = 65536;
      for (int j = 0; j < k; j++)
        if (j != i)
          basis = fx_mul(basis, fx_div(t - wp_time[j], wp_time[i] - wp_time[j], sat), sat);
      acc_w += fx_mul(basis, wp_turn[i], sat);
      acc_v += fx_mul(basis, wp_speed[i], sat);
    end
    r.lin_speed = 32'(clamp32(acc_v, sat));
    r.turn_rate = 32'(clamp32(acc_w, sat));
    r.status    = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      npoints    <= PC_RESET;
      errors_o   <= 0;
      mismatches = 0;
      profile_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) npoints <= cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        if (in_item_i.cmd == CMD_LOAD) begin
          wp_time[in_item_i.point_index]  = longint'(in_item_i.node_time);
          wp_turn[in_item_i.point_index]  = longint'(in_item_i.node_turn_rate);
          wp_speed[in_item_i.point_index] = longint'(in_item_i.node_speed);
        end else begin
          profile_q.push_back(interpolate(in_item_i.eval_time));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (profile_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", out_item_i);
        end else begin
          exp_r = profile_q.pop_front();
          if (exp_r.lin_speed !== out_item_i.lin_speed ||
              exp_r.turn_rate !== out_item_i.turn_rate ||
              exp_r.status !== out_item_i.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp lin %h turn %h st %0d, got lin %h turn %h st %0d",
                       exp_r.lin_speed, exp_r.turn_rate, exp_r.status,
                       out_item_i.lin_speed, out_item_i.turn_rate, out_item_i.status);
          end
        end
      end
      errors_o <= mismatches;
    end
  end

  assign pending_o = profile_q.size();
endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for lagrange_speed_profile
// Loads waypoint tables, sweeps point_count, drives directed and random load
// and evaluate items under varying idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lsp_pkg::*;

  localparam int WATCHDOG = 60000;
  localparam int HOLD_CYC = 12000;

  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_valid = 0;
  logic       in_ready;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_ready = 0;
  out_item_t  out_item;
  logic       cfg_valid = 0;
  logic       cfg_ready;
  logic [3:0] cfg_data = '0;
  int         errors;
  int         pending;
  int         send_idle = 0;
  int         recv_stall = 0;
  logic       long_hold = 0;
  int         hold_cnt = 0;
  int         quiet = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  lagrange_speed_profile DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  lsp_scoreboard u_scoreboard (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_item_i(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  // receiver; the long hold runs once, counted here
  always @(posedge clk) begin
    if (long_hold && hold_cnt < HOLD_CYC) begin
      hold_cnt  <= hold_cnt + 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send(input in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_wp(input logic [2:0] slot, input logic [31:0] t,
                         input logic [31:0] w, input logic [31:0] v);
    in_item_t it;
    it                = '0;
    it.cmd            = CMD_LOAD;
    it.point_index    = slot;
    it.node_time      = t;
    it.node_turn_rate = w;
    it.node_speed     = v;
    it.eval_time      = $urandom;
    send(it);
  endtask

  task automatic evaluate(input logic [31:0] t);
    in_item_t it;
    it           = '0;
    it.cmd       = CMD_EVAL;
    it.point_index = 3'($urandom);
    it.node_time = $urandom;
    it.node_turn_rate = $urandom;
    it.node_speed = $urandom;
    it.eval_time = t;
    send(it);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_points(input logic [3:0] n);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] small_val();
    return 32'($signed($urandom_range(0, 1048575)) - 524288);
  endfunction

  task automatic random_item;
    logic [2:0] s;
    if ($urandom_range(99) < 35) begin
      if ($urandom_range(99) < 70) evaluate(32'($signed($urandom_range(0, 655360)) - 65536));
      else evaluate($urandom);
    end else begin
      s = 3'($urandom_range(7));
      load_wp(s,
              ($urandom_range(99) < 85) ? 32'(s * 65536 + $urandom_range(0, 4095)) : $urandom,
              ($urandom_range(99) < 70) ? small_val() : $urandom,
              ($urandom_range(99) < 70) ? small_val() : $urandom);
    end
  endtask

  initial begin
    logic [3:0] counts [10];
    counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd4};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fill every slot, then extremes and equal times
    for (int i = 0; i < 8; i++)
      load_wp(3'(i), 32'(i * 65536), small_val(), small_val());
    evaluate(32'h0000_0000);
    evaluate(32'h0001_8000);
    evaluate(32'h7FFF_FFFF);
    evaluate(32'h8000_0000);
    load_wp(3'd3, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    evaluate(32'h0002_8000);
    load_wp(3'd1, 32'h0000_0000, small_val(), small_val());
    evaluate(32'h0001_0000);
    load_wp(3'd1, 32'h0001_0000, small_val(), small_val());
    load_wp(3'd7, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    load_wp(3'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    evaluate(32'h0000_4000);
    load_wp(3'd0, 32'h0000_0000, small_val(), small_val());

    // sender pauses until every result is back
    drain();

    // long receiver hold while evaluates keep coming with two points
    set_points(4'd2);
    long_hold <= 1'b1;
    for (int i = 0; i < 12; i++) evaluate(32'($urandom_range(0, 196608)));
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      set_points(counts[ph]);
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 63; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 63; end
        default: begin send_idle = 21; recv_stall = 21; end
      endcase
      for (int n = 0; n < 22; n++) random_item();
    end

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/lsp_pkg.sv
rtl/lsp_div.sv
rtl/lsp_datapath.sv
rtl/lsp_ctrl.sv
rtl/lagrange_speed_profile.sv
rtl/lsp_checker.sv
tb/lsp_checker.sv
tb/tb_top.sv
